// ===== sv/aeskx_pkg.sv =====
// Package for the AES-128 key expansion unit.
// Holds the transaction payload types, the S-box function and round constants.
// No dependencies.
package aeskx_pkg;

    typedef struct packed {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
    } key_in_t;

    typedef struct packed {
        logic [63:0] round_key_hi;
        logic [63:0] round_key_lo;
        logic [3:0]  round_number;
        logic        last_key;
    } key_out_t;

    localparam logic [3:0] LAST_ROUND = 4'd10;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    // Round constant applied when producing round r (1..10).
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        unique case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/aeskx_round.sv =====
// One shared key schedule round: RotWord, SubWord, Rcon and word chaining.
// Depends on aeskx_pkg.
module aeskx_round
    import aeskx_pkg::*;
(
    input  logic [127:0] key,
    input  logic [3:0]   round,
    output logic [127:0] next_key
);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2;

    assign w0 = key[127:96];
    assign w1 = key[95:64];
    assign w2 = key[63:32];
    assign w3 = key[31:0];

    // Rotated word run through the S-box, then the round constant on the top byte.
    assign t = {sbox(w3[23:16]) ^ rcon(round), sbox(w3[15:8]),
                sbox(w3[7:0]), sbox(w3[31:24])};

    assign n0 = w0 ^ t;
    assign n1 = w1 ^ n0;
    assign n2 = w2 ^ n1;
    assign next_key = {n0, n1, n2, w3 ^ n2};
endmodule

// ===== sv/aes128_key_expansion_unit.sv =====
// AES-128 key expansion unit: one cipher key in, eleven round keys out.
// Round keys: round 0 is offered in the cycle after the key transaction; each later
// round key follows in the cycle after the previous one is taken.
// A new key is accepted only after the last round key is taken: the key is loaded,
// then eleven round key transactions come from the single shared round unit.
// Reset: rst_n asynchronous active low; returns the unit to idle, ready for a key.
module aes128_key_expansion_unit
    import aeskx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  key_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output key_out_t out_data
);
    // The output register holds the current round key and doubles as the
    // working state for the shared round unit.
    logic         busy_reg, busy_next;
    logic [127:0] key_reg, key_next;
    logic [3:0]   round_reg, round_next;
    logic [127:0] round_out;
    logic [3:0]   round_inc;

    assign round_inc = round_reg + 4'd1;

    aeskx_round u_round (
        .key      (key_reg),
        .round    (round_inc),
        .next_key (round_out)
    );

    // A new key is taken only when no run is in flight.
    assign in_ready  = !busy_reg;
    assign out_valid = busy_reg;
    assign out_data  = '{round_key_hi: key_reg[127:64],
                         round_key_lo: key_reg[63:0],
                         round_number: round_reg,
                         last_key:     (round_reg == LAST_ROUND)};

    always_comb
    begin
        busy_next  = busy_reg;
        key_next   = key_reg;
        round_next = round_reg;
        if (!busy_reg && in_valid)
        begin
            busy_next  = 1'b1;
            key_next   = {in_data.key_hi, in_data.key_lo};
            round_next = 4'd0;
        end
        else if (busy_reg && out_ready)
        begin
            if (round_reg == LAST_ROUND)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                key_next   = round_out;
                round_next = round_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= 4'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end
endmodule
